// ===== hdl/multi_client_watchdog_checkin_top_macros.svh =====
// Assertion helpers for the watchdog check-in supervisor.
// Both expect clk and rst in the scope where they are used.
`ifndef MULTI_CLIENT_WATCHDOG_CHECKIN_TOP_MACROS_SVH
`define MULTI_CLIENT_WATCHDOG_CHECKIN_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define MCWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MCWD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MCWD_ASSERT(lbl, prop, msg)
`define MCWD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/mcwd_pkg.sv =====
`timescale 1ns / 1ps

package mcwd_pkg;

  localparam int MAX_CLIENTS_DEF = 31;
  localparam int FORCE_SLOT_DEF  = 0;

  localparam int REQ_W     = 3;
  localparam int ID_W      = 6;
  localparam int STATUS_W  = 2;
  localparam int GRANT_W   = 5;
  localparam int PERIOD_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam logic             ENABLED_RST = 1'b1;
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLED     = 1'b0,
    CFG_FEED_PERIOD = 1'b1
  } cfg_idx_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC   = 3'd0,
    REQ_CHECKIN = 3'd1,
    REQ_PAUSE   = 3'd2,
    REQ_FORCE   = 3'd3,
    REQ_TICK    = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOPERM = 2'd1,
    ST_INVAL  = 2'd2
  } status_t;

endpackage

// ===== hdl/multi_client_watchdog_checkin_top.sv =====
`timescale 1ns / 1ps

// Watchdog check-in supervisor. One request item is accepted per clock unless
// the master side stalls; its result is registered. The masks, allocator and
// feed countdown are all updated in the single cycle of acceptance, so
// back-to-back items see each other's effects. s_axis_tready falls only while
// a finished result is held by a stalled master side. Configuration writes
// take effect on the next clock and must be issued while the block is idle.
`include "multi_client_watchdog_checkin_top_macros.svh"

module multi_client_watchdog_checkin_top
  import mcwd_pkg::*;
#(
  parameter int MAX_CLIENTS = MAX_CLIENTS_DEF,
  parameter int FORCE_SLOT  = FORCE_SLOT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [5:0] client_id
  input  logic [7:0]           s_axis_tuser,   // [2:0] req_type

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [1:0] status, [6:2] granted_id,
                                               // [7] feed_pulse, [8] feed_refused

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // mask covers the reserved slot even when it lies above the client range
  localparam int MW  = (MAX_CLIENTS > FORCE_SLOT) ? MAX_CLIENTS : FORCE_SLOT + 1;
  localparam int NCW = $clog2(MW + 2);
  localparam logic [NCW-1:0] NC_RST = (FORCE_SLOT == 0) ? NCW'(1) : NCW'(0);

  typedef struct packed {
    status_t             status;
    logic [GRANT_W-1:0]  granted_id;
    logic                feed_pulse;
    logic                feed_refused;
  } result_t;

  logic                enabled;
  logic [PERIOD_W-1:0] feed_period_ticks;

  logic [MW-1:0]       pending;
  logic [MW-1:0]       pending_next;
  logic [MW-1:0]       req_mask;
  logic [MW-1:0]       req_mask_next;
  logic [NCW-1:0]      next_client;
  logic [NCW-1:0]      next_client_next;
  logic                ids_exhausted;
  logic                ids_exhausted_next;
  logic [PERIOD_W-1:0] countdown;
  logic [PERIOD_W-1:0] countdown_next;

  result_t             res;
  result_t             res_next;

  logic                accept;
  logic [REQ_W-1:0]    in_req;
  logic [ID_W-1:0]     in_id;
  logic                id_ok;
  logic [MW-1:0]       id_bit;
  logic [MW-1:0]       force_bit;
  logic [NCW-1:0]      nc_inc;
  logic [NCW-1:0]      nc_skip;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_req        = s_axis_tuser[REQ_W-1:0];
  assign in_id         = s_axis_tdata[ID_W-1:0];

  assign id_ok     = (ID_W+1)'(in_id) < (ID_W+1)'(MAX_CLIENTS);
  assign id_bit    = MW'(1) << in_id;
  assign force_bit = MW'(1) << FORCE_SLOT;
  assign nc_inc    = next_client + NCW'(1);
  assign nc_skip   = (nc_inc == NCW'(FORCE_SLOT)) ? nc_inc + NCW'(1) : nc_inc;

  always_comb begin
    pending_next       = pending;
    req_mask_next      = req_mask;
    next_client_next   = next_client;
    ids_exhausted_next = ids_exhausted;
    countdown_next     = countdown;
    res_next           = '{status: ST_OK, granted_id: '0, feed_pulse: 1'b0,
                           feed_refused: 1'b0};

    if (!enabled) begin
      res_next.status = ST_NOPERM;
    end else begin
      case (in_req)
        REQ_ALLOC: begin
          if (ids_exhausted || next_client >= NCW'(MAX_CLIENTS)) begin
            ids_exhausted_next = 1'b1;
            res_next.status    = ST_NOPERM;
          end else begin
            res_next.granted_id = GRANT_W'(next_client);
            if (nc_skip >= NCW'(MAX_CLIENTS)) begin
              // saturate on the last id
              ids_exhausted_next = 1'b1;
              next_client_next   = NCW'(MAX_CLIENTS - 1);
            end else begin
              next_client_next = nc_skip;
            end
          end
        end
        REQ_CHECKIN: begin
          if (!id_ok) begin
            res_next.status = ST_INVAL;
          end else begin
            pending_next  = pending | id_bit;
            req_mask_next = req_mask | id_bit;
          end
        end
        REQ_PAUSE: begin
          if (!id_ok) begin
            res_next.status = ST_INVAL;
          end else begin
            pending_next  = pending & ~id_bit;
            req_mask_next = req_mask & ~id_bit;
          end
        end
        REQ_FORCE: begin
          req_mask_next = req_mask | force_bit;
        end
        REQ_TICK: begin
          if (countdown == '0) begin
            if (pending == req_mask) begin
              pending_next        = '0;
              res_next.feed_pulse = 1'b1;
            end else begin
              res_next.feed_refused = 1'b1;
            end
            countdown_next = (feed_period_ticks == '0) ? '0
                                                       : feed_period_ticks - PERIOD_W'(1);
          end else begin
            countdown_next = countdown - PERIOD_W'(1);
          end
        end
        default: begin
          res_next.status = ST_NOPERM;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled           <= ENABLED_RST;
      feed_period_ticks <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLED:     enabled           <= cfg_data[0];
        CFG_FEED_PERIOD: feed_period_ticks <= cfg_data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= '0;
      req_mask      <= '0;
      next_client   <= NC_RST;
      ids_exhausted <= (NCW'(MAX_CLIENTS) <= NC_RST);
      countdown     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        pending       <= pending_next;
        req_mask      <= req_mask_next;
        next_client   <= next_client_next;
        ids_exhausted <= ids_exhausted_next;
        countdown     <= countdown_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_axis_tdata = 16'({res.feed_refused, res.feed_pulse, res.granted_id, res.status});

  `MCWD_ASSERT(a_pending_in_mask, (pending & ~req_mask) == '0,
               "pending check-in outside the required mask")
  `MCWD_ASSERT(a_exhausted_saturates,
               ids_exhausted |-> (next_client == NCW'(MAX_CLIENTS - 1)),
               "allocator exhausted but counter not saturated")
  `MCWD_ASSERT(a_feed_clears_pending, (accept && res_next.feed_pulse) |=> (pending == '0),
               "feed issued without clearing pending check-ins")
  `MCWD_ASSERT(a_feed_exclusive, m_axis_tvalid |-> !(res.feed_pulse && res.feed_refused),
               "feed pulse and refusal in one result")
  `MCWD_ASSERT(a_grant_only_ok,
               (m_axis_tvalid && res.granted_id != '0) |-> (res.status == ST_OK),
               "id granted on a failed request")
  `MCWD_ASSERT_ALWAYS(a_reset_idle, rst |=> !m_axis_tvalid,
                      "result valid right after reset")

endmodule
